>>> hw/rtl/line_sensor_steering_assert.svh
// Assertion macros for the checker file lss_checker.sv.
`ifndef LINE_SENSOR_STEERING_ASSERT_SVH
`define LINE_SENSOR_STEERING_ASSERT_SVH

// Hold cons in the same cycle as ante, outside reset.
`define LSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Hold cons in the cycle after ante, outside reset.
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Hold cons in the cycle after ante, also across reset.
`define LSS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lss_pkg.sv
package lss_pkg;

   localparam int NUM_SENSORS      = 16;
   localparam int SENSORS_PER_CELL = 4;
   localparam int NUM_CELLS        = NUM_SENSORS / SENSORS_PER_CELL;
   localparam int CELL_IDX_W       = $clog2(NUM_CELLS);
   localparam int LANE_W           = $clog2(SENSORS_PER_CELL);
   localparam int IDX_W            = $clog2(NUM_SENSORS);
   localparam int CNT_W            = IDX_W + 1;
   localparam int MID_W            = IDX_W + 1;

   localparam int FRAME_W  = 64;
   localparam int TIME_W   = 32;
   localparam int CMD_W    = 16;
   localparam int MARGIN_W = 12;
   localparam int HOLD_W   = 16;
   localparam int RUN_W    = 4;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Signed coefficients and the proportional numerator.
   localparam int COEF_W = CMD_W + 2;
   localparam int NUM_W  = COEF_W + 6;

   localparam logic [CMD_W-1:0]    SERVO_HIGH_RST  = 16'd2100;
   localparam logic [CMD_W-1:0]    SERVO_LOW_RST   = 16'd900;
   localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = 12'd200;
   localparam logic [HOLD_W-1:0]   HOLDOFF_RST     = 16'd300;
   localparam logic [RUN_W-1:0]    BAND_LOW_RST    = 4'd3;
   localparam logic [RUN_W-1:0]    BAND_HIGH_RST   = 4'd6;
   localparam logic [RUN_W-1:0]    TURN_LENGTH_RST = 4'd8;

   localparam logic [MID_W-1:0] MID_CENTRE = 5'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERVO_HIGH  = 3'd0,
      CSR_SERVO_LOW   = 3'd1,
      CSR_EDGE_MARGIN = 3'd2,
      CSR_HOLDOFF     = 3'd3,
      CSR_BAND_LOW    = 3'd4,
      CSR_BAND_HIGH   = 3'd5,
      CSR_TURN_LENGTH = 3'd6
   } csr_index_type;

   // Travels along the cell row.
   typedef struct packed {
      logic [NUM_SENSORS-1:0] lit;
      logic [IDX_W-1:0]       first;
      logic [IDX_W-1:0]       last;
      logic [CNT_W-1:0]       count;
      logic [TIME_W-1:0]      now_ms;
   } scan_type;

   // Decision inputs for the steering stage.
   typedef struct packed {
      logic              active;
      logic              prop_ok;
      logic              hard_ok;
      logic              hard_hi;
      logic [CMD_W-1:0]  prop_cmd;
      logic [TIME_W-1:0] now_ms;
   } steer_type;

endpackage

>>> hw/rtl/lss_req_if.sv
interface lss_req_if;
   logic                       valid;
   logic                       ready;
   logic [lss_pkg::FRAME_W-1:0] lower_frame;
   logic [lss_pkg::FRAME_W-1:0] upper_frame;
   logic [lss_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, output lower_frame, output upper_frame, output now_ms,
                   input ready);
   modport sink   (input valid, input lower_frame, input upper_frame, input now_ms,
                   output ready);
endinterface

>>> hw/rtl/lss_rsp_if.sv
interface lss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lss_pkg::CMD_W-1:0] servo_command;
   logic                      hard_turn;

   modport source (output valid, output servo_command, output hard_turn, input ready);
   modport sink   (input valid, input servo_command, input hard_turn, output ready);
endinterface

>>> hw/rtl/lss_cell.sv
module lss_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lss_pkg::CELL_IDX_W-1:0]      cell_idx,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  lss_pkg::scan_type                   in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output lss_pkg::scan_type                   out_data
);

   logic              valid_ff;
   lss_pkg::scan_type data_ff;
   lss_pkg::scan_type data_in;

   // Fold this cell's sensors into the running first/last/count.
   always_comb begin
      logic [lss_pkg::IDX_W-1:0] idx;
      data_in = in_data;
      for (int j = 0; j < lss_pkg::SENSORS_PER_CELL; j++) begin
         idx = {cell_idx, lss_pkg::LANE_W'(j)};
         if (data_in.lit[idx]) begin
            if (data_in.count == '0) begin
               data_in.first = idx;
            end
            data_in.last  = idx;
            data_in.count = data_in.count + lss_pkg::CNT_W'(1);
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hw/rtl/lss_shape.sv
module lss_shape (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  lss_pkg::scan_type                    in_data,
   input  logic signed [lss_pkg::COEF_W-1:0]    coef_a,
   input  logic signed [lss_pkg::COEF_W-1:0]    coef_b,
   input  logic [lss_pkg::RUN_W-1:0]            band_low,
   input  logic [lss_pkg::RUN_W-1:0]            band_high,
   input  logic [lss_pkg::RUN_W-1:0]            turn_length,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output lss_pkg::steer_type                   out_data
);

   localparam int NUM_W = lss_pkg::NUM_W;

   logic                      valid_ff;
   lss_pkg::steer_type        data_ff;
   lss_pkg::steer_type        data_in;
   logic [lss_pkg::MID_W-1:0] mid;
   logic [lss_pkg::RUN_W-1:0] run;
   logic signed [NUM_W-1:0]   mid_ext;
   logic signed [NUM_W-1:0]   b_ext;
   logic signed [NUM_W-1:0]   a16;
   logic signed [NUM_W-1:0]   prod;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-5:0]          quot;

   always_comb begin
      // Widen the sum by a bit: first + last + 2 reaches 32 for sensor fifteen alone.
      mid  = lss_pkg::MID_W'(((lss_pkg::MID_W+1)'(in_data.first)
             + (lss_pkg::MID_W+1)'(in_data.last) + (lss_pkg::MID_W+1)'(2)) >> 1);
      run  = lss_pkg::RUN_W'(in_data.count - lss_pkg::CNT_W'(1));
      mid_ext = $signed({{(NUM_W - lss_pkg::MID_W){1'b0}}, mid});
      b_ext   = $signed({{(NUM_W - lss_pkg::COEF_W){coef_b[lss_pkg::COEF_W-1]}}, coef_b});
      a16     = $signed({{(NUM_W - lss_pkg::COEF_W - 4){coef_a[lss_pkg::COEF_W-1]}},
                         coef_a, 4'b0000});
      prod    = mid_ext * b_ext;
      num     = a16 - prod;
      quot    = num[NUM_W-1:4];

      data_in.active  = in_data.count != '0;
      data_in.prop_ok = (run >= band_low) && (run <= band_high);
      data_in.hard_ok = (run >= turn_length) || (in_data.count == lss_pkg::CNT_W'(1));
      data_in.hard_hi = mid < lss_pkg::MID_CENTRE;
      data_in.now_ms  = in_data.now_ms;
      // Negative numerators truncate to zero or below: clamp to zero; saturate on overflow.
      priority if (num[NUM_W-1]) begin
         data_in.prop_cmd = '0;
      end else if (quot[NUM_W-5:lss_pkg::CMD_W] != '0) begin
         data_in.prop_cmd = '1;
      end else begin
         data_in.prop_cmd = quot[lss_pkg::CMD_W-1:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hw/rtl/lss_steer.sv
module lss_steer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lss_pkg::steer_type            in_data,
   input  logic [lss_pkg::CMD_W-1:0]     servo_high,
   input  logic [lss_pkg::CMD_W-1:0]     servo_low,
   input  logic [lss_pkg::HOLD_W-1:0]    holdoff_ms,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lss_pkg::CMD_W-1:0]     servo_command,
   output logic                          hard_turn
);

   logic                       valid_ff;
   logic [lss_pkg::CMD_W-1:0]  held_ff;
   logic [lss_pkg::TIME_W-1:0] turn_ff;
   logic                       hard_ff;
   logic [lss_pkg::TIME_W-1:0] elapsed;
   logic                       go;

   assign elapsed = in_data.now_ms - turn_ff;
   assign go      = in_data.active
                    && (elapsed >= {{(lss_pkg::TIME_W - lss_pkg::HOLD_W){1'b0}}, holdoff_ms});

   assign in_ready      = !valid_ff || out_ready;
   assign out_valid     = valid_ff;
   assign servo_command = held_ff;
   assign hard_turn     = hard_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         held_ff  <= '0;
         turn_ff  <= '0;
         hard_ff  <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         if (in_valid) begin
            priority if (go && in_data.prop_ok) begin
               held_ff <= in_data.prop_cmd;
               hard_ff <= 1'b0;
            end else if (go && in_data.hard_ok) begin
               held_ff <= in_data.hard_hi ? servo_high : servo_low;
               turn_ff <= in_data.now_ms;
               hard_ff <= 1'b1;
            end else begin
               held_ff <= held_ff;
               hard_ff <= 1'b0;
            end
         end
      end
   end

endmodule

>>> hw/rtl/line_sensor_steering.sv
// Steering command from a sixteen-sensor line bar.
// req_ch (sink): one transaction carries lower_frame, upper_frame (eight sensor
//   bytes each, a sensor counts as lit when its byte is exactly one) and now_ms.
// rsp_ch (source): one transaction per request, in order, with servo_command
//   (the held command after this update) and hard_turn.
// csr_we/csr_index/csr_wdata: register writes, taken on any edge with csr_we
//   high; write only while no request is in flight.
// Pipeline: a request passes through four cells of the sensor row, one stage for
//   the proportional term (one small multiply) and one output register that also
//   holds the steering state.
// Throughput: one transaction per cycle while rsp_ch.ready stays high; every stage
//   takes a new transaction while its neighbour downstream drains, so a stalled
//   receiver first fills the six stages before req_ch.ready drops.
// Reset: registers return to their defaults, the held command and the last
//   turn time go to zero and the pipeline empties.
module line_sensor_steering (
   input  logic                           clock,
   input  logic                           reset,
   lss_req_if.sink                        req_ch,
   lss_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [lss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lss_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int NUM_CELLS = lss_pkg::NUM_CELLS;

   // Configuration registers.
   logic [lss_pkg::CMD_W-1:0]    servo_high_ff;
   logic [lss_pkg::CMD_W-1:0]    servo_low_ff;
   logic [lss_pkg::MARGIN_W-1:0] edge_margin_ff;
   logic [lss_pkg::HOLD_W-1:0]   holdoff_ff;
   logic [lss_pkg::RUN_W-1:0]    band_low_ff;
   logic [lss_pkg::RUN_W-1:0]    band_high_ff;
   logic [lss_pkg::RUN_W-1:0]    turn_length_ff;

   // Derived coefficients, settled long before a transaction reaches them.
   logic signed [lss_pkg::COEF_W-1:0] coef_a_ff;
   logic signed [lss_pkg::COEF_W-1:0] coef_b_ff;
   logic signed [lss_pkg::COEF_W-1:0] coef_a_in;
   logic signed [lss_pkg::COEF_W-1:0] coef_b_in;

   logic                cell_valid [0:NUM_CELLS];
   logic                cell_ready [0:NUM_CELLS];
   lss_pkg::scan_type   cell_data  [0:NUM_CELLS];

   logic                shape_valid;
   logic                shape_ready;
   lss_pkg::steer_type  shape_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_high_ff  <= lss_pkg::SERVO_HIGH_RST;
         servo_low_ff   <= lss_pkg::SERVO_LOW_RST;
         edge_margin_ff <= lss_pkg::EDGE_MARGIN_RST;
         holdoff_ff     <= lss_pkg::HOLDOFF_RST;
         band_low_ff    <= lss_pkg::BAND_LOW_RST;
         band_high_ff   <= lss_pkg::BAND_HIGH_RST;
         turn_length_ff <= lss_pkg::TURN_LENGTH_RST;
      end else if (csr_we) begin
         unique case (lss_pkg::csr_index_type'(csr_index))
            lss_pkg::CSR_SERVO_HIGH:  servo_high_ff  <= csr_wdata[lss_pkg::CMD_W-1:0];
            lss_pkg::CSR_SERVO_LOW:   servo_low_ff   <= csr_wdata[lss_pkg::CMD_W-1:0];
            lss_pkg::CSR_EDGE_MARGIN: edge_margin_ff <= csr_wdata[lss_pkg::MARGIN_W-1:0];
            lss_pkg::CSR_HOLDOFF:     holdoff_ff     <= csr_wdata[lss_pkg::HOLD_W-1:0];
            lss_pkg::CSR_BAND_LOW:    band_low_ff    <= csr_wdata[lss_pkg::RUN_W-1:0];
            lss_pkg::CSR_BAND_HIGH:   band_high_ff   <= csr_wdata[lss_pkg::RUN_W-1:0];
            lss_pkg::CSR_TURN_LENGTH: turn_length_ff <= csr_wdata[lss_pkg::RUN_W-1:0];
            default: begin
               // drop writes to unused indices
            end
         endcase
      end
   end

   // A = high - margin, B = high - low - 2*margin, both exact in signed form.
   assign coef_a_in = $signed({2'b00, servo_high_ff})
                      - $signed({{(lss_pkg::COEF_W - lss_pkg::MARGIN_W){1'b0}}, edge_margin_ff});
   assign coef_b_in = $signed({2'b00, servo_high_ff}) - $signed({2'b00, servo_low_ff})
                      - $signed({{(lss_pkg::COEF_W - lss_pkg::MARGIN_W - 1){1'b0}},
                                 edge_margin_ff, 1'b0});

   always_ff @(posedge clock) begin
      coef_a_ff <= coef_a_in;
      coef_b_ff <= coef_b_in;
   end

   // Decode the sensor bytes; the frames list sensors from the top byte down.
   always_comb begin
      cell_data[0] = '0;
      for (int i = 0; i < 8; i++) begin
         cell_data[0].lit[i]     = req_ch.lower_frame[8*(7-i) +: 8] == 8'd1;
         cell_data[0].lit[i + 8] = req_ch.upper_frame[8*(7-i) +: 8] == 8'd1;
      end
      cell_data[0].now_ms = req_ch.now_ms;
   end

   assign cell_valid[0] = req_ch.valid;
   assign req_ch.ready  = cell_ready[0];

   // Row of scan cells: each folds its group of sensors and hands on.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      lss_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (lss_pkg::CELL_IDX_W'(g)),
         .in_valid  (cell_valid[g]),
         .in_ready  (cell_ready[g]),
         .in_data   (cell_data[g]),
         .out_valid (cell_valid[g+1]),
         .out_ready (cell_ready[g+1]),
         .out_data  (cell_data[g+1])
      );
   end

   lss_shape u_shape (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cell_valid[NUM_CELLS]),
      .in_ready    (cell_ready[NUM_CELLS]),
      .in_data     (cell_data[NUM_CELLS]),
      .coef_a      (coef_a_ff),
      .coef_b      (coef_b_ff),
      .band_low    (band_low_ff),
      .band_high   (band_high_ff),
      .turn_length (turn_length_ff),
      .out_valid   (shape_valid),
      .out_ready   (shape_ready),
      .out_data    (shape_data)
   );

   // Apply holdoff, update the held command and present the result.
   lss_steer u_steer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (shape_valid),
      .in_ready      (shape_ready),
      .in_data       (shape_data),
      .servo_high    (servo_high_ff),
      .servo_low     (servo_low_ff),
      .holdoff_ms    (holdoff_ff),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .servo_command (rsp_ch.servo_command),
      .hard_turn     (rsp_ch.hard_turn)
   );

endmodule

>>> hw/rtl/lss_checker.sv
`include "line_sensor_steering_assert.svh"

module lss_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [lss_pkg::CMD_W-1:0] servo_command,
   input logic                      hard_turn
);

   // Transactions accepted but not yet delivered.
   logic [2:0] pending_ff;
   logic [2:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 3'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `LSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `LSS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(servo_command) && $stable(hard_turn), "response changed while stalled")
   `LSS_ASSERT_NOW(a_no_spurious, rsp_valid, pending_ff != 3'd0, "response without request")
   `LSS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "response right after reset")

endmodule

bind line_sensor_steering lss_checker u_lss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .servo_command (rsp_ch.servo_command),
   .hard_turn     (rsp_ch.hard_turn)
);
